FILE: hdl/swbte_pkg.sv
// ----------------------------------------------------------------------------
// swbte_pkg
// Shared types and constants for the stopwatch bank on a wrap-extended tick.
// ----------------------------------------------------------------------------
package swbte_pkg;

  localparam int unsigned NumWatchesDef = 8;
  localparam int unsigned ModeW         = 3;
  localparam int unsigned IdxFieldW     = 3;
  localparam int unsigned TickW         = 32;
  localparam int unsigned TimeW         = 64;

  typedef enum logic [ModeW-1:0] {
    ModeInit  = 3'd0,
    ModeStart = 3'd1,
    ModeStop  = 3'd2,
    ModeRead  = 3'd3,
    ModeReset = 3'd4,
    ModeQuery = 3'd5
  } mode_e;

  // Command presented to the watch bank in the cycle it is executed
  typedef struct packed {
    logic  fire;
    mode_e mode;
    logic  in_range;
  } cmd_t;

endpackage

FILE: hdl/stopwatch_bank_tick_extend.sv
// ----------------------------------------------------------------------------
// stopwatch_bank_tick_extend
// Stopwatch bank timed by a 32-bit tick extended to 64 bits by wrap counting.
// ----------------------------------------------------------------------------
// Result path: input register, then result register; an untaken result stalls.
// Throughput: one item per cycle while each result is taken when offered; the
// state update of one item completes in the cycle it leaves the input register,
// so the next item sees it.
// Reset: clock, base tick and all watches cleared (stopped, zero).
module stopwatch_bank_tick_extend #(
  parameter int unsigned NUM_WATCHES = swbte_pkg::NumWatchesDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [swbte_pkg::ModeW-1:0]     mode_i,
  input  logic [swbte_pkg::IdxFieldW-1:0] watch_index_i,
  input  logic [swbte_pkg::TickW-1:0]     tick_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [swbte_pkg::TimeW-1:0]     elapsed_o,
  output logic                            running_o
);
  import swbte_pkg::*;

  localparam int unsigned IdxW = (NUM_WATCHES > 1) ? $clog2(NUM_WATCHES) : 1;
  localparam logic [7:0]  NumWatchesC = 8'(NUM_WATCHES);

  logic                 s1_valid_q;
  mode_e                s1_mode_q;
  logic [IdxFieldW-1:0] s1_idx_q;
  logic [TickW-1:0]     s1_tick_q;

  logic             out_valid_q;
  logic [TimeW-1:0] elapsed_q;
  logic             running_q;

  logic             advance;
  cmd_t             cmd;
  logic [IdxW-1:0]  sel;
  logic [TimeW-1:0] now;
  logic             sample;
  logic [TimeW-1:0] bank_elapsed;
  logic             bank_running;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_mode_q <= mode_e'(mode_i);
      s1_idx_q  <= watch_index_i;
      s1_tick_q <= tick_i;
    end
  end

  assign sel          = IdxW'(s1_idx_q);
  assign cmd.fire     = advance;
  assign cmd.mode     = s1_mode_q;
  assign cmd.in_range = {{(8-IdxFieldW){1'b0}}, s1_idx_q} < NumWatchesC;

  swbte_clock u_clock (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .init_i   (advance && s1_mode_q == ModeInit),
    .sample_i (sample),
    .tick_i   (s1_tick_q),
    .now_o    (now)
  );

  swbte_bank #(
    .NUM_WATCHES (NUM_WATCHES),
    .IdxW        (IdxW)
  ) u_bank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sel_i     (sel),
    .now_i     (now),
    .sample_o  (sample),
    .elapsed_o (bank_elapsed),
    .running_o (bank_running)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      elapsed_q <= bank_elapsed;
      running_q <= bank_running;
    end
  end

  assign out_valid_o = out_valid_q;
  assign elapsed_o   = elapsed_q;
  assign running_o   = running_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("executed item produced no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !advance)
    else $error("pending result overwritten");

  a_stalled_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q && $stable(s1_tick_q) && $stable(s1_idx_q))
    else $error("input register lost a waiting item");

endmodule

FILE: hdl/swbte_clock.sv
// ----------------------------------------------------------------------------
// swbte_clock
// 64-bit clock built from 32-bit tick samples; gives time since init.
// ----------------------------------------------------------------------------
module swbte_clock (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        init_i,
  input  logic                        sample_i,
  input  logic [swbte_pkg::TickW-1:0] tick_i,
  output logic [swbte_pkg::TimeW-1:0] now_o
);
  import swbte_pkg::*;

  logic [TimeW-1:0] clock_q, clock_d;
  logic [TickW-1:0] base_tick_q;
  logic [TickW-1:0] hi_d;

  // lower sample than last one: tick counter wrapped
  always_comb begin
    hi_d = clock_q[TimeW-1:TickW];
    if (tick_i < clock_q[TickW-1:0]) begin
      hi_d = clock_q[TimeW-1:TickW] + TickW'(1);
    end
    clock_d = {hi_d, tick_i};
  end

  assign now_o = clock_d - {{(TimeW-TickW){1'b0}}, base_tick_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_q     <= '0;
      base_tick_q <= '0;
    end else if (init_i) begin
      clock_q     <= {{(TimeW-TickW){1'b0}}, tick_i};
      base_tick_q <= tick_i;
    end else if (sample_i) begin
      clock_q <= clock_d;
    end
  end

  a_wrap_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_i && !init_i |=>
      (clock_q[TimeW-1:TickW] == $past(clock_q[TimeW-1:TickW])) ||
      (clock_q[TimeW-1:TickW] == $past(clock_q[TimeW-1:TickW]) + TickW'(1)))
    else $error("wrap count moved by more than one");

  a_init_clock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_i |=> clock_q[TimeW-1:TickW] == '0 && clock_q[TickW-1:0] == base_tick_q)
    else $error("init did not load clock and base tick");

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !init_i && !sample_i |=> $stable(clock_q) && $stable(base_tick_q))
    else $error("clock changed without a sample");

endmodule

FILE: hdl/swbte_bank.sv
// ----------------------------------------------------------------------------
// swbte_bank
// Stopwatch state (base, stop, running) and the per-command arithmetic.
// ----------------------------------------------------------------------------
module swbte_bank #(
  parameter int unsigned NUM_WATCHES = swbte_pkg::NumWatchesDef,
  parameter int unsigned IdxW        = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  swbte_pkg::cmd_t             cmd_i,
  input  logic [IdxW-1:0]             sel_i,
  input  logic [swbte_pkg::TimeW-1:0] now_i,
  output logic                        sample_o,
  output logic [swbte_pkg::TimeW-1:0] elapsed_o,
  output logic                        running_o
);
  import swbte_pkg::*;

  logic [TimeW-1:0]       base_q [NUM_WATCHES];
  logic [TimeW-1:0]       stop_q [NUM_WATCHES];
  logic [NUM_WATCHES-1:0] run_q;

  logic [TimeW-1:0] cur_base, cur_stop, base_d, stop_d;
  logic             cur_run, run_d;
  logic             sample, wr_base, wr_stop, wr_run;

  assign cur_base = base_q[sel_i];
  assign cur_stop = stop_q[sel_i];
  assign cur_run  = run_q[sel_i];

  always_comb begin
    sample    = 1'b0;
    wr_base   = 1'b0;
    wr_stop   = 1'b0;
    wr_run    = 1'b0;
    base_d    = cur_base;
    stop_d    = cur_stop;
    run_d     = cur_run;
    elapsed_o = '0;
    if (cmd_i.in_range) begin
      unique case (cmd_i.mode)
        ModeStart: begin
          sample  = 1'b1;
          base_d  = cur_base + now_i - cur_stop;
          wr_base = 1'b1;
          run_d   = 1'b1;
          wr_run  = 1'b1;
        end
        ModeStop: begin
          sample    = 1'b1;
          stop_d    = now_i;
          wr_stop   = 1'b1;
          run_d     = 1'b0;
          wr_run    = 1'b1;
          elapsed_o = now_i - cur_base;
        end
        ModeRead: begin
          // clock only advances when the watch is running
          sample    = cur_run;
          elapsed_o = (cur_run ? now_i : cur_stop) - cur_base;
        end
        ModeReset: begin
          sample  = 1'b1;
          base_d  = now_i;
          stop_d  = now_i;
          wr_base = 1'b1;
          wr_stop = 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign sample_o  = cmd_i.fire && sample;
  assign running_o = (cmd_i.mode != ModeInit) && cmd_i.in_range && run_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= '0;
      for (int i = 0; i < NUM_WATCHES; i++) begin
        base_q[i] <= '0;
        stop_q[i] <= '0;
      end
    end else if (cmd_i.fire && cmd_i.mode == ModeInit) begin
      run_q <= '0;
      for (int i = 0; i < NUM_WATCHES; i++) begin
        base_q[i] <= '0;
        stop_q[i] <= '0;
      end
    end else if (cmd_i.fire && cmd_i.in_range) begin
      if (wr_base) begin
        base_q[sel_i] <= base_d;
      end
      if (wr_stop) begin
        stop_q[sel_i] <= stop_d;
      end
      if (wr_run) begin
        run_q[sel_i] <= run_d;
      end
    end
  end

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire && cmd_i.in_range && cmd_i.mode == ModeStop |=> !run_q[$past(sel_i)])
    else $error("watch still running after stop");

  a_init_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire && cmd_i.mode == ModeInit |=> run_q == '0)
    else $error("watches still running after init");

  a_elapsed_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fire && !(cmd_i.in_range && (cmd_i.mode == ModeStop || cmd_i.mode == ModeRead))
      |-> elapsed_o == '0)
    else $error("non-zero elapsed on a command that reports none");

endmodule
